// File: rtl/core/erff_pkg.sv
// Shared types and constants for the Ethernet receive frame filter.
`timescale 1ns / 1ps
package erff_pkg;

	localparam int unsigned LEN_W     = 16;
	localparam int unsigned MAC_W     = 48;
	localparam int unsigned TYPE_W    = 16;
	localparam int unsigned CNT_W     = 64;
	localparam int unsigned IN_DATA_W = LEN_W + MAC_W + TYPE_W;
	localparam int unsigned OUT_DATA_W = 6 * CNT_W;

	// minimum frame length: the Ethernet header
	localparam int unsigned HEADER_BYTES = 14;

	localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};
	// group bit: LSB of the first octet
	localparam int unsigned MAC_GROUP_BIT = MAC_W - 8;

	localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;
	localparam logic [TYPE_W-1:0] TYPE_ARP  = 16'h0806;
	localparam logic [TYPE_W-1:0] TYPE_IPV6 = 16'h86DD;
	localparam logic [TYPE_W-1:0] TYPE_VLAN = 16'h8100;

	typedef enum logic [2:0] {
		VERDICT_IPV4     = 3'd0,
		VERDICT_ARP      = 3'd1,
		VERDICT_SHORT    = 3'd2,
		VERDICT_NOT_OURS = 3'd3,
		VERDICT_IPV6     = 3'd4,
		VERDICT_VLAN     = 3'd5,
		VERDICT_UNKNOWN  = 3'd6
	} verdict_t;

	typedef struct packed {
		verdict_t verdict;
		logic     bcast;
		logic     mcast;
		logic     err;
		logic     drop;
	} class_t;

endpackage

// File: rtl/core/ethernet_rx_frame_filter.sv
// Ethernet receive frame filter: top level with input stage, counters and output stage.
`timescale 1ns / 1ps
// Takes one frame summary per transfer on s_* and returns one verdict plus the six
// statistics counters (after this frame) on m_*. Stage 1 registers the summary, the output
// register verdict and counters; a new summary is accepted every cycle, limited only by
// m_tready. Frames shorter than the HEADER_LEN-byte header (14 by default) are errors
// and drops; frames not broadcast, multicast or addressed to own_mac are dropped;
// IPv4 and ARP are delivered, other EtherTypes dropped. Counters are 64 bits and wrap.
// own_mac is written through cfg_* and should only be changed while no frame is in flight.
module ethernet_rx_frame_filter
	import erff_pkg::*;
#(
	parameter int unsigned HEADER_LEN = HEADER_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: own_mac
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MAC_W-1:0]      cfg_data,
	// input: frame_length[15:0], dst_addr[63:16], ethertype[79:64]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// output: total_packets[63:0], total_bytes[127:64], total_errors[191:128],
	// total_drops[255:192], total_multicast[319:256], total_broadcast[383:320]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// output: verdict[2:0], seen_broadcast[3], seen_multicast[4]
	output logic [4:0]            m_tuser
);

	logic [MAC_W-1:0]  own_mac_q;

	logic              valid_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [MAC_W-1:0]  dest_s1;
	logic [TYPE_W-1:0] type_s1;

	logic              valid_s2;
	class_t            cls_s2;

	logic [CNT_W-1:0]  packets_q, bytes_q, errors_q, drops_q, mcast_q, bcast_q;

	class_t            cls;
	logic              advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_mac_q <= cfg_data;
		end
	end

	// stage 1 moves into the output register when it is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			len_s1  <= s_tdata[LEN_W-1:0];
			dest_s1 <= s_tdata[LEN_W +: MAC_W];
			type_s1 <= s_tdata[LEN_W+MAC_W +: TYPE_W];
		end
	end

	erff_classify #(
		.HEADER_LEN (HEADER_LEN)
	) u_classify (
		.frame_length (len_s1),
		.dst_addr     (dest_s1),
		.ethertype    (type_s1),
		.own_mac      (own_mac_q),
		.cls          (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			packets_q <= '0;
			bytes_q   <= '0;
			errors_q  <= '0;
			drops_q   <= '0;
			mcast_q   <= '0;
			bcast_q   <= '0;
		end else begin
			if (advance) begin
				valid_s2  <= 1'b1;
				packets_q <= packets_q + CNT_W'(1);
				bytes_q   <= bytes_q + CNT_W'(len_s1);
				errors_q  <= errors_q + CNT_W'(cls.err);
				drops_q   <= drops_q + CNT_W'(cls.drop);
				mcast_q   <= mcast_q + CNT_W'(cls.mcast);
				bcast_q   <= bcast_q + CNT_W'(cls.bcast);
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s2 <= cls;
		end
	end

	// counters hold until the next transfer, so they double as the output payload
	assign m_tvalid = valid_s2;
	assign m_tdata  = {bcast_q, mcast_q, drops_q, errors_q, bytes_q, packets_q};
	assign m_tuser  = {cls_s2.mcast, cls_s2.bcast, cls_s2.verdict};

endmodule

// File: rtl/core/erff_classify.sv
// Frame classifier: length check, address filter and EtherType decode.
`timescale 1ns / 1ps
module erff_classify
	import erff_pkg::*;
#(
	parameter int unsigned HEADER_LEN = HEADER_BYTES
) (
	input  logic [LEN_W-1:0]  frame_length,
	input  logic [MAC_W-1:0]  dst_addr,
	input  logic [TYPE_W-1:0] ethertype,
	input  logic [MAC_W-1:0]  own_mac,
	output class_t            cls
);

	logic     short_frame;
	logic     is_bcast;
	logic     is_group;
	verdict_t type_verdict;

	assign short_frame = frame_length < LEN_W'(HEADER_LEN);
	assign is_bcast    = dst_addr == MAC_BROADCAST;
	assign is_group    = dst_addr[MAC_GROUP_BIT];

	always_comb begin
		case (ethertype)
			TYPE_IPV4: type_verdict = VERDICT_IPV4;
			TYPE_ARP:  type_verdict = VERDICT_ARP;
			TYPE_IPV6: type_verdict = VERDICT_IPV6;
			TYPE_VLAN: type_verdict = VERDICT_VLAN;
			default:   type_verdict = VERDICT_UNKNOWN;
		endcase
	end

	always_comb begin
		cls = '0;
		if (short_frame) begin
			// destination not examined on a runt
			cls.verdict = VERDICT_SHORT;
			cls.err     = 1'b1;
			cls.drop    = 1'b1;
		end else begin
			cls.bcast = is_bcast;
			cls.mcast = !is_bcast && is_group;
			if (!is_group && dst_addr != own_mac) begin
				cls.verdict = VERDICT_NOT_OURS;
				cls.drop    = 1'b1;
			end else begin
				cls.verdict = type_verdict;
				cls.drop    = !(type_verdict == VERDICT_IPV4 || type_verdict == VERDICT_ARP);
			end
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench for the Ethernet receive frame filter: directed table, random frames, predictor.
`timescale 1ns / 1ps
module tb_top;
	import erff_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned NUM_PHASES = 5;
	localparam int unsigned NUM_ROWS = 18;
	localparam logic [MAC_W-1:0] GROUP_MASK = MAC_W'(1) << MAC_GROUP_BIT;

	typedef struct packed {
		verdict_t         verdict;
		logic             bcast;
		logic             mcast;
		logic [CNT_W-1:0] pkts;
		logic [CNT_W-1:0] octets;
		logic [CNT_W-1:0] errs;
		logic [CNT_W-1:0] drops;
		logic [CNT_W-1:0] mcasts;
		logic [CNT_W-1:0] bcasts;
	} frame_result_t;

	// one directed frame; when typed, verdict and flags are checked as written here
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [MAC_W-1:0]  dest;
		logic [TYPE_W-1:0] etype;
		logic              typed;
		verdict_t          verdict;
		logic              bcast;
		logic              mcast;
	} frame_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [MAC_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [4:0]            m_tuser;

	// filter state mirrored by the predictor
	logic [MAC_W-1:0] own_mac;
	logic [CNT_W-1:0] pkt_cnt, byte_cnt, err_cnt, drop_cnt, mcast_cnt, bcast_cnt;

	frame_result_t pending_results[$];
	int unsigned   mismatches;
	int unsigned   cycles;
	bit            idle_on;
	bit            hold_output;

	// own_mac is zero after reset for every row
	frame_row_t directed_rows[NUM_ROWS] = '{
		'{16'd0,     MAC_BROADCAST,      TYPE_IPV4, 1'b1, VERDICT_SHORT,    1'b0, 1'b0},
		'{16'd13,    48'h01005E000001,   TYPE_ARP,  1'b1, VERDICT_SHORT,    1'b0, 1'b0},
		'{16'd5,     48'h000000000000,   TYPE_IPV4, 1'b1, VERDICT_SHORT,    1'b0, 1'b0},
		'{16'd14,    MAC_BROADCAST,      TYPE_IPV4, 1'b1, VERDICT_IPV4,     1'b1, 1'b0},
		'{16'hFFFF,  MAC_BROADCAST,      TYPE_ARP,  1'b1, VERDICT_ARP,      1'b1, 1'b0},
		'{16'd64,    48'h01005E7F0001,   TYPE_IPV6, 1'b1, VERDICT_IPV6,     1'b0, 1'b1},
		'{16'd64,    48'h333300000001,   TYPE_VLAN, 1'b1, VERDICT_VLAN,     1'b0, 1'b1},
		'{16'd64,    48'h010000000000,   16'h0000,  1'b1, VERDICT_UNKNOWN,  1'b0, 1'b1},
		'{16'd1518,  48'hFFFFFFFFFFFE,   16'hFFFF,  1'b1, VERDICT_UNKNOWN,  1'b0, 1'b1},
		'{16'd60,    48'h000000000000,   TYPE_IPV4, 1'b1, VERDICT_IPV4,     1'b0, 1'b0},
		'{16'd60,    48'h000000000000,   TYPE_ARP,  1'b1, VERDICT_ARP,      1'b0, 1'b0},
		'{16'd60,    48'h020000000001,   TYPE_IPV4, 1'b1, VERDICT_NOT_OURS, 1'b0, 1'b0},
		'{16'd60,    48'hFEFFFFFFFFFF,   TYPE_ARP,  1'b1, VERDICT_NOT_OURS, 1'b0, 1'b0},
		'{16'd60,    48'h00AABBCCDDEE,   TYPE_IPV6, 1'b1, VERDICT_NOT_OURS, 1'b0, 1'b0},
		'{16'd60,    48'h000000000000,   TYPE_IPV6, 1'b1, VERDICT_IPV6,     1'b0, 1'b0},
		'{16'd60,    48'h000000000000,   TYPE_VLAN, 1'b1, VERDICT_VLAN,     1'b0, 1'b0},
		'{16'd15,    48'h01FFFFFFFFFF,   TYPE_IPV4, 1'b0, VERDICT_IPV4,     1'b0, 1'b0},
		'{16'hFFFF,  48'h000000000000,   16'h0805,  1'b0, VERDICT_IPV4,     1'b0, 1'b0}
	};

	ethernet_rx_frame_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic frame_result_t filter_frame(input logic [LEN_W-1:0] len,
		input logic [MAC_W-1:0] dest, input logic [TYPE_W-1:0] etype);
		frame_result_t r;
		r.bcast = 1'b0;
		r.mcast = 1'b0;
		pkt_cnt  = pkt_cnt + 1;
		byte_cnt = byte_cnt + CNT_W'(len);
		if (len < HEADER_BYTES) begin
			err_cnt  = err_cnt + 1;
			drop_cnt = drop_cnt + 1;
			r.verdict = VERDICT_SHORT;
		end else begin
			r.bcast = (dest == MAC_BROADCAST);
			r.mcast = !r.bcast && dest[MAC_GROUP_BIT];
			if (r.bcast)
				bcast_cnt = bcast_cnt + 1;
			else if (r.mcast)
				mcast_cnt = mcast_cnt + 1;
			if (!r.bcast && !r.mcast && dest != own_mac) begin
				r.verdict = VERDICT_NOT_OURS;
			end else begin
				case (etype)
					TYPE_IPV4: r.verdict = VERDICT_IPV4;
					TYPE_ARP:  r.verdict = VERDICT_ARP;
					TYPE_IPV6: r.verdict = VERDICT_IPV6;
					TYPE_VLAN: r.verdict = VERDICT_VLAN;
					default:   r.verdict = VERDICT_UNKNOWN;
				endcase
			end
			if (r.verdict != VERDICT_IPV4 && r.verdict != VERDICT_ARP)
				drop_cnt = drop_cnt + 1;
		end
		r.pkts   = pkt_cnt;
		r.octets = byte_cnt;
		r.errs   = err_cnt;
		r.drops  = drop_cnt;
		r.mcasts = mcast_cnt;
		r.bcasts = bcast_cnt;
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the transfer happened
	task automatic send_frame(input frame_row_t row);
		int unsigned gap;
		frame_result_t r;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.etype, row.dest, row.len};
		do @(posedge clk); while (!s_tready);
		r = filter_frame(row.len, row.dest, row.etype);
		if (row.typed) begin
			r.verdict = row.verdict;
			r.bcast   = row.bcast;
			r.mcast   = row.mcast;
		end
		pending_results.push_back(r);
	endtask

	task automatic send_random_frame();
		frame_row_t row;
		int unsigned pick;
		row = '0;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			row.len = LEN_W'($urandom_range(0, HEADER_BYTES - 1));
		else if (pick < 16)
			row.len = LEN_W'(HEADER_BYTES);
		else if (pick < 20)
			row.len = '1;
		else if (pick < 35)
			row.len = LEN_W'($urandom);
		else
			row.len = LEN_W'($urandom_range(HEADER_BYTES, 1518));
		pick = $urandom_range(0, 99);
		row.dest = {16'($urandom), $urandom};
		if (pick < 30)
			row.dest = own_mac;
		else if (pick < 45)
			row.dest = MAC_BROADCAST;
		else if (pick < 65)
			row.dest = row.dest | GROUP_MASK;
		else if (pick < 80)
			row.dest = row.dest & ~GROUP_MASK;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			row.etype = TYPE_IPV4;
		else if (pick < 45)
			row.etype = TYPE_ARP;
		else if (pick < 60)
			row.etype = TYPE_IPV6;
		else if (pick < 75)
			row.etype = TYPE_VLAN;
		else
			row.etype = TYPE_W'($urandom);
		send_frame(row);
	endtask

	task automatic write_own_mac(input logic [MAC_W-1:0] mac);
		cfg_valid <= 1'b1;
		cfg_data  <= mac;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		own_mac = mac;
	endtask

	// drain results, then let the pipeline settle
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", what, want, got);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: user %0h", m_tuser);
			end else begin
				want = pending_results.pop_front();
				check_field("verdict", CNT_W'(want.verdict), CNT_W'(m_tuser[2:0]));
				check_field("seen_broadcast", CNT_W'(want.bcast), CNT_W'(m_tuser[3]));
				check_field("seen_multicast", CNT_W'(want.mcast), CNT_W'(m_tuser[4]));
				check_field("total_packets", want.pkts, m_tdata[63:0]);
				check_field("total_bytes", want.octets, m_tdata[127:64]);
				check_field("total_errors", want.errs, m_tdata[191:128]);
				check_field("total_drops", want.drops, m_tdata[255:192]);
				check_field("total_multicast", want.mcasts, m_tdata[319:256]);
				check_field("total_broadcast", want.bcasts, m_tdata[383:320]);
			end
		end
	end

	// receiver: random stalls, and a long hold-off on request
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [MAC_W-1:0] mac;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cycles      = 0;
		mismatches  = 0;
		idle_on     = 1'b1;
		hold_output = 1'b0;
		own_mac     = '0;
		pkt_cnt     = '0;
		byte_cnt    = '0;
		err_cnt     = '0;
		drop_cnt    = '0;
		mcast_cnt   = '0;
		bcast_cnt   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_frame(directed_rows[i]);
		s_tvalid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			mac = {16'($urandom), $urandom};
			case (p)
				0: mac = MAC_BROADCAST;
				1: mac = mac & ~GROUP_MASK;
				2: mac = mac | GROUP_MASK;
				3: mac = '0;
				default: mac = mac & ~GROUP_MASK;
			endcase
			write_own_mac(mac);
			// phase 0 runs back to back on both sides
			idle_on = (p != 0);
			if (p == 2 || p == 4)
				hold_output = 1'b1;
			repeat (ITEMS_PER_PHASE) send_random_frame();
			s_tvalid <= 1'b0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/erff_pkg.sv
rtl/core/erff_classify.sv
rtl/core/ethernet_rx_frame_filter.sv
tb/tb_top.sv
